### src/sset_pkg.sv
package sset_pkg;

  // Store size and the widths that follow from it.
  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;

  // Field widths of the result channel.
  localparam int POSITION_W = 6;
  localparam int TOTAL_W    = 7;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 3;

  // Request kinds.
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_EXACT  = 2'd1,
    MODE_FLOOR  = 2'd2
  } mode_t;

  // Result codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // Controls broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp_en;
    logic shift_en;
  } cell_ctrl_t;

  // Compare flags each cell reports back.
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

### src/sset_cell.sv
module sset_cell
  import sset_pkg::*;
(
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic                    occupied,
  input  logic signed [KEY_W-1:0] search_key,
  input  logic signed [KEY_W-1:0] insert_key,
  input  logic                    lt_prev,
  input  logic signed [KEY_W-1:0] prev_key,
  output logic signed [KEY_W-1:0] key_r,
  output cell_flags_t             flags_r
);

  logic signed [KEY_W-1:0] key_nxt;
  cell_flags_t             flags_nxt;

  // Compare the held key with the key of a new transaction.
  always_comb begin
    flags_nxt = flags_r;
    if (ctrl.cmp_en) begin
      flags_nxt.lt = occupied && (key_r < search_key);
      flags_nxt.eq = occupied && (key_r == search_key);
    end
  end

  // On insert, cells at or above the insert point take the key from below;
  // the cell at the insert point itself takes the new key.
  always_comb begin
    key_nxt = key_r;
    if (ctrl.shift_en && !flags_r.lt) begin
      key_nxt = lt_prev ? insert_key : prev_key;
    end
  end

  // Payload only, no reset needed.
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    flags_r <= flags_nxt;
  end

endmodule

### src/sorted_set_insert_and_search.sv
// Channel   Direction  Fields                                   Handshake
// in_       input      mode[1:0], key[31:0] signed              in_valid / in_stall
// out_      output     status[2:0], position[5:0], total[6:0]   out_valid / out_stall
//
// Each transaction passes through the accept cycle, in which every cell of the
// chain compares its key, and the update cycle, in which the insert point is
// decoded, the cells shift and the result is registered.
// Synchronous active-low reset empties the store; the cell keys are not cleared.
// A new transaction is accepted while the previous result still waits; the
// update cycle repeats while the output register is held by out_stall.
module sorted_set_insert_and_search
  import sset_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic signed [KEY_W-1:0] in_key,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STATUS_W-1:0]     out_status,
  output logic [POSITION_W-1:0]   out_position,
  output logic [TOTAL_W-1:0]      out_entry_total
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [MODE_W-1:0]       mode_r;
  logic signed [KEY_W-1:0] key_r;
  logic [CNT_W-1:0]        count_r, count_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [POSITION_W-1:0]   out_position_r, out_position_nxt;
  logic [TOTAL_W-1:0]      out_total_r, out_total_nxt;

  logic                    in_accept;
  logic                    out_free;
  logic                    commit;
  cell_ctrl_t              ctrl;

  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  cell_flags_t             cell_flags [CAPACITY];
  logic [CAPACITY-1:0]     occupied;
  logic [CAPACITY-1:0]     lt_vec;
  logic [CAPACITY-1:0]     lt_prev;
  logic [CAPACITY-1:0]     boundary;

  logic [CNT_W-1:0]        below;
  logic [CNT_W-1:0]        not_above;
  logic                    present;
  logic                    is_full;
  logic                    do_insert;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign commit    = (state_r == S_UPDATE) && out_free;

  // Occupancy of each place follows from the count.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occupied[i] = (CNT_W'(i) < count_r);
    end
  end

  // Below-key flags form a prefix; the insert point is where it ends.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_vec[i] = cell_flags[i].lt;
    end
    lt_prev = {lt_vec[CAPACITY-2:0], 1'b1};
    boundary = lt_prev & ~lt_vec;
  end

  // Decode the insert point and whether the key is already held.
  always_comb begin
    below   = '0;
    present = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (boundary[i]) begin
        below = below | CNT_W'(i);
      end
      present = present | (boundary[i] & cell_flags[i].eq);
    end
    if (lt_vec[CAPACITY-1]) begin
      below = CNT_W'(CAPACITY);
    end
    not_above = below + CNT_W'(present);
    is_full   = (count_r == CNT_W'(CAPACITY));
  end

  // Result and count for the transaction in the update cycle.
  always_comb begin
    do_insert        = 1'b0;
    count_nxt        = count_r;
    out_status_nxt   = ST_NOT_FOUND;
    out_position_nxt = '0;
    unique case (mode_r)
      MODE_INSERT: begin
        if (present) begin
          out_status_nxt   = ST_PRESENT;
          out_position_nxt = POSITION_W'(below);
        end else if (is_full) begin
          out_status_nxt = ST_FULL;
        end else begin
          do_insert        = 1'b1;
          count_nxt        = count_r + 1'b1;
          out_status_nxt   = ST_INSERTED;
          out_position_nxt = POSITION_W'(below);
        end
      end
      MODE_EXACT: begin
        if (present) begin
          out_status_nxt   = ST_FOUND;
          out_position_nxt = POSITION_W'(below);
        end
      end
      MODE_FLOOR: begin
        if (not_above != '0) begin
          out_status_nxt   = ST_FOUND;
          out_position_nxt = POSITION_W'(not_above - 1'b1);
        end
      end
      default: begin
        out_status_nxt = ST_NOT_FOUND;
      end
    endcase
    out_total_nxt = TOTAL_W'(count_nxt);
  end

  assign ctrl.cmp_en   = in_accept;
  assign ctrl.shift_en = commit && do_insert;

  // The chain of cells; each cell sees its lower neighbor, the first sees the request key.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [KEY_W-1:0] prev_key;
    if (g == 0) begin : g_first
      assign prev_key = key_r;
    end else begin : g_rest
      assign prev_key = cell_key[g-1];
    end
    sset_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occupied[g]),
      .search_key (in_key),
      .insert_key (key_r),
      .lt_prev    (lt_prev[g]),
      .prev_key   (prev_key),
      .key_r      (cell_key[g]),
      .flags_r    (cell_flags[g])
    );
  end

  // Sequencing between accept and update cycles.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        count_r <= count_nxt;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_r <= in_mode;
      key_r  <= in_key;
    end
    if (commit) begin
      out_status_r   <= out_status_nxt;
      out_position_r <= out_position_nxt;
      out_total_r    <= out_total_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_position    = out_position_r;
  assign out_entry_total = out_total_r;

endmodule
